>>> rtl/dtf_pkg.sv
// Package: widths, calendar constants and the month-offset table for the FAT time converter.
package dtf_pkg;

  localparam int DATE_W  = 16;
  localparam int TIME_W  = 16;
  localparam int TICKS_W = 58;
  localparam int YEAR_W  = 8;
  localparam int DOY_W   = 9;
  localparam int TOD_W   = 17;
  localparam int DAYS_W  = 18;
  localparam int SECS_W  = 34;
  localparam int HALF_W  = 17;
  localparam int PROD_W  = 41;

  // Days from 1601-01-01 to 1 March of 1979, the first shifted year.
  localparam logic [DAYS_W-1:0] DAY_BASE      = 18'd138120;
  localparam logic [DAYS_W-1:0] DAYS_PER_YEAR = 18'd365;
  localparam logic [YEAR_W-1:0] CENTURY_SKIP  = 8'd121;
  localparam logic [SECS_W-1:0] SECS_PER_DAY  = 34'd86400;
  localparam logic [TOD_W-1:0]  SECS_PER_HOUR = 17'd3600;
  localparam logic [TOD_W-1:0]  SECS_PER_MIN  = 17'd60;
  localparam logic [PROD_W-1:0] TICKS_PER_SEC = 41'd10000000;

  typedef logic [TICKS_W-1:0] ticks_t;
  typedef logic [SECS_W-1:0]  secs_t;

  // Day of a March-based year on which each month starts.
  function automatic logic [DOY_W-1:0] month_start(input logic [3:0] mp);
    logic [DOY_W-1:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/dtf_scale.sv
// Two-stage seconds to 100 ns tick scaler built from two half-width products.
module dtf_scale (
  input  logic              clk,
  input  logic              en,
  input  dtf_pkg::secs_t    secs,
  output dtf_pkg::ticks_t   ticks
);

  logic [dtf_pkg::PROD_W-1:0] prod_lo;
  logic [dtf_pkg::PROD_W-1:0] prod_hi;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_lo <= dtf_pkg::PROD_W'(secs[dtf_pkg::HALF_W-1:0]) * dtf_pkg::TICKS_PER_SEC;
      prod_hi <= dtf_pkg::PROD_W'(secs[dtf_pkg::SECS_W-1:dtf_pkg::HALF_W])
                 * dtf_pkg::TICKS_PER_SEC;
      ticks   <= {prod_hi, {dtf_pkg::HALF_W{1'b0}}} + dtf_pkg::TICKS_W'(prod_lo);
    end
  end

endmodule

>>> rtl/dos_timestamp_to_filetime.sv
// Top level: packed FAT date and time words to FILETIME ticks, five register stages.
// Throughput: one request per cycle; the whole pipeline holds while a shown result is stalled.
// Reset: synchronous rst clears every stage valid bit; data registers are not reset.
// Stall: a stalled result stalls the request in the same cycle, empty stages included.
module dos_timestamp_to_filetime (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic [dtf_pkg::DATE_W-1:0]     dos_date,
  input  logic [dtf_pkg::TIME_W-1:0]     dos_time,
  output logic                           res_valid,
  input  logic                           res_stall,
  output logic [dtf_pkg::TICKS_W-1:0]    filetime_ticks
);

  logic [3:0] vld;
  logic       en;

  logic [6:0] year_off;
  logic [3:0] month;
  logic [4:0] day;
  logic [4:0] hour;
  logic [5:0] minute;
  logic [4:0] sec2;
  logic       late;
  logic [3:0] mp;
  logic       ok_in;

  logic                        ok1;
  logic [dtf_pkg::YEAR_W-1:0]  yp1;
  logic [dtf_pkg::DOY_W-1:0]   doy1;
  logic [dtf_pkg::TOD_W-1:0]   tod1;

  logic                        ok2;
  logic [dtf_pkg::DAYS_W-1:0]  days2;
  logic [dtf_pkg::TOD_W-1:0]   tod2;

  dtf_pkg::secs_t              secs3;

  assign en        = !(res_valid && res_stall);
  assign req_stall = !en;

  assign year_off = dos_date[15:9];
  assign month    = dos_date[8:5];
  assign day      = dos_date[4:0];
  assign hour     = dos_time[15:11];
  assign minute   = dos_time[10:5];
  assign sec2     = dos_time[4:0];

  assign late  = month > 4'd2;
  assign mp    = late ? month - 4'd3 : month + 4'd9;
  assign ok_in = (month >= 4'd1) && (month <= 4'd12) && (day != 5'd0) &&
                 (hour <= 5'd23) && (minute <= 6'd59) && (sec2 <= 5'd29);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      res_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[2:0], req_valid};
      res_valid <= vld[3];
    end
  end

  // Stage 1: unpack, range check, day of shifted year and second of day.
  always_ff @(posedge clk) begin
    if (en) begin
      ok1  <= ok_in;
      yp1  <= {1'b0, year_off} + dtf_pkg::YEAR_W'(late);
      doy1 <= dtf_pkg::month_start(mp) + dtf_pkg::DOY_W'(day) - 9'd1;
      tod1 <= dtf_pkg::TOD_W'(hour) * dtf_pkg::SECS_PER_HOUR +
              dtf_pkg::TOD_W'(minute) * dtf_pkg::SECS_PER_MIN +
              dtf_pkg::TOD_W'({sec2, 1'b0});
    end
  end

  // Stage 2: day count since 1601-01-01.
  always_ff @(posedge clk) begin
    if (en) begin
      ok2   <= ok1;
      tod2  <= tod1;
      days2 <= dtf_pkg::DAY_BASE + dtf_pkg::DAYS_W'(yp1) * dtf_pkg::DAYS_PER_YEAR +
               dtf_pkg::DAYS_W'((dtf_pkg::DOY_W'(yp1) + 9'd3) >> 2) -
               dtf_pkg::DAYS_W'(yp1 >= dtf_pkg::CENTURY_SKIP) +
               dtf_pkg::DAYS_W'(doy1);
    end
  end

  // Stage 3: seconds since 1601-01-01, zero for a rejected request.
  always_ff @(posedge clk) begin
    if (en) begin
      secs3 <= ok2 ? dtf_pkg::SECS_W'(days2) * dtf_pkg::SECS_PER_DAY +
                     dtf_pkg::SECS_W'(tod2)
                   : '0;
    end
  end

  // Stages 4 and 5: scale to ticks.
  dtf_scale u_scale (
    .clk   (clk),
    .en    (en),
    .secs  (secs3),
    .ticks (filetime_ticks)
  );

endmodule

>>> rtl/dtf_checker.sv
// Checker: port-level properties of the FAT time converter, bound to the top level.
module dtf_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           req_valid,
  input logic                           req_stall,
  input logic [dtf_pkg::DATE_W-1:0]     dos_date,
  input logic [dtf_pkg::TIME_W-1:0]     dos_time,
  input logic                           res_valid,
  input logic                           res_stall,
  input logic [dtf_pkg::TICKS_W-1:0]    filetime_ticks
);

  logic bad_req;

  assign bad_req = (dos_date[8:5] == 4'd0) || (dos_date[8:5] > 4'd12) ||
                   (dos_date[4:0] == 5'd0) || (dos_time[15:11] > 5'd23) ||
                   (dos_time[10:5] > 6'd59) || (dos_time[4:0] > 5'd29);

  a_hold_valid : assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid)
    else $error("result dropped while stalled");

  a_hold_ticks : assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> $stable(filetime_ticks))
    else $error("stalled result changed");

  a_range : assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (filetime_ticks == '0) ||
                  ((filetime_ticks >= 58'd119600064000000000) &&
                   (filetime_ticks <= 58'd159992927980000000)))
    else $error("result outside the FAT time range");

  a_bad_zero : assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && bad_req ##1 !req_stall ##1 !req_stall ##1 !req_stall
      ##1 !req_stall |-> ##1 (res_valid && (filetime_ticks == '0)))
    else $error("rejected request gave a non-zero result");

  a_no_stall_idle : assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> !req_stall)
    else $error("request stalled with an empty result register");

endmodule

bind dos_timestamp_to_filetime dtf_checker u_dtf_checker (.*);

>>> verif/tb_dos_timestamp_to_filetime.sv
// Testbench: FAT date/time words to FILETIME ticks, checked request by request against a predictor.
module tb_dos_timestamp_to_filetime;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 12;
  localparam int PHASE_ITEMS    = 445;

  localparam logic [3:0] MON_JAN = 4'd1;
  localparam logic [3:0] MON_FEB = 4'd2;
  localparam logic [3:0] MON_MAR = 4'd3;
  localparam logic [3:0] MON_APR = 4'd4;
  localparam logic [3:0] MON_JUN = 4'd6;
  localparam logic [3:0] MON_DEC = 4'd12;

  class tick_scoreboard;
    dtf_pkg::ticks_t expected_ticks[$];
    int              errors;

    function dtf_pkg::ticks_t predict_ticks(logic [dtf_pkg::DATE_W-1:0] d,
                                            logic [dtf_pkg::TIME_W-1:0] t);
      longint unsigned yr, mon, dy, hr, mi, sc;
      longint unsigned y, era, yoe, mp, doy, doe, days, secs;
      yr  = 64'd1980 + 64'(d[15:9]);
      mon = 64'(d[8:5]);
      dy  = 64'(d[4:0]);
      hr  = 64'(t[15:11]);
      mi  = 64'(t[10:5]);
      sc  = 64'd2 * 64'(t[4:0]);
      if (mon < 1 || mon > 12 || dy < 1 || hr > 23 || mi > 59 || sc > 59)
        return '0;
      y    = yr - ((mon <= 2) ? 64'd1 : 64'd0);
      era  = y / 400;
      yoe  = y - era * 400;
      mp   = (mon > 2) ? mon - 3 : mon + 9;
      doy  = (64'd153 * mp + 2) / 5 + dy - 1;
      doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      days = era * 64'd146097 + doe - 64'd719468;
      secs = days * 64'd86400 + hr * 3600 + mi * 60 + sc + 64'd11644473600;
      return dtf_pkg::ticks_t'(secs * 64'd10000000);
    endfunction

    function void note_request(logic [dtf_pkg::DATE_W-1:0] d, logic [dtf_pkg::TIME_W-1:0] t);
      expected_ticks.push_back(predict_ticks(d, t));
    endfunction

    function void check_result(dtf_pkg::ticks_t got);
      dtf_pkg::ticks_t want;
      if (expected_ticks.size() == 0) begin
        $display("%0t: filetime_ticks expected none, actual %0d", $time, got);
        errors++;
        return;
      end
      want = expected_ticks.pop_front();
      if (got !== want) begin
        $display("%0t: filetime_ticks expected %0d, actual %0d", $time, want, got);
        errors++;
      end
    endfunction

    function int outstanding();
      return expected_ticks.size();
    endfunction
  endclass

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       req_valid = 1'b0;
  logic                       req_stall;
  logic [dtf_pkg::DATE_W-1:0] dos_date  = '0;
  logic [dtf_pkg::TIME_W-1:0] dos_time  = '0;
  logic                       res_valid;
  logic                       res_stall = 1'b0;
  dtf_pkg::ticks_t            filetime_ticks;

  tick_scoreboard sb = new();
  int send_idle   = 0;
  int stall_pct   = 0;
  int idle_cycles = 0;

  dos_timestamp_to_filetime uut (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .dos_date       (dos_date),
    .dos_time       (dos_time),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .filetime_ticks (filetime_ticks)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    res_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && req_valid && !req_stall) sb.note_request(dos_date, dos_time);
    if (!rst && res_valid && !res_stall) sb.check_result(filetime_ticks);
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [dtf_pkg::DATE_W-1:0] pack_date(logic [6:0] yr, logic [3:0] mon,
                                                           logic [4:0] dy);
    return {yr, mon, dy};
  endfunction

  function automatic logic [dtf_pkg::TIME_W-1:0] pack_time(logic [4:0] hr, logic [5:0] mi,
                                                           logic [4:0] s2);
    return {hr, mi, s2};
  endfunction

  task automatic send_req(input logic [dtf_pkg::DATE_W-1:0] d,
                          input logic [dtf_pkg::TIME_W-1:0] t);
    while ($urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    dos_date  <= d;
    dos_time  <= t;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic send_random();
    logic [6:0] yr;
    logic [3:0] mon;
    logic [4:0] dy, hr, s2;
    logic [5:0] mi;
    int         bad;
    if ($urandom_range(9) == 0) begin
      send_req(16'($urandom), 16'($urandom));
      return;
    end
    yr  = 7'($urandom_range(127));
    mon = 4'($urandom_range(12, 1));
    dy  = 5'($urandom_range(31, 1));
    hr  = 5'($urandom_range(23));
    mi  = 6'($urandom_range(59));
    s2  = 5'($urandom_range(29));
    if ($urandom_range(99) < 4) begin
      bad = int'($urandom_range(3));
      mon = (bad == 0) ? 4'd0 : 4'(12 + bad);
    end
    if ($urandom_range(99) < 4) dy = 5'd0;
    if ($urandom_range(99) < 4) hr = 5'($urandom_range(31, 24));
    if ($urandom_range(99) < 4) mi = 6'($urandom_range(63, 60));
    if ($urandom_range(99) < 4) s2 = 5'($urandom_range(31, 30));
    send_req(pack_date(yr, mon, dy), pack_time(hr, mi, s2));
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int idle, input int stall, input int count);
    send_idle = idle;
    stall_pct = stall;
    repeat (count) send_random();
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_req(pack_date(7'd0, MON_JAN, 5'd1), pack_time(5'd0, 6'd0, 5'd0));
    send_req(pack_date(7'd127, MON_DEC, 5'd31), pack_time(5'd23, 6'd59, 5'd29));
    send_req(16'h0000, 16'h0000);
    send_req(16'hFFFF, 16'hFFFF);
    send_req(pack_date(7'd0, MON_FEB, 5'd29), pack_time(5'd12, 6'd30, 5'd15));
    send_req(pack_date(7'd1, MON_FEB, 5'd31), pack_time(5'd1, 6'd2, 5'd3));
    send_req(pack_date(7'd120, MON_FEB, 5'd29), pack_time(5'd6, 6'd7, 5'd8));
    send_req(pack_date(7'd20, MON_FEB, 5'd29), pack_time(5'd23, 6'd0, 5'd0));
    send_req(pack_date(7'd5, MON_APR, 5'd31), pack_time(5'd10, 6'd10, 5'd10));
    send_req(pack_date(7'd5, MON_MAR, 5'd1), pack_time(5'd0, 6'd0, 5'd1));
    send_req(pack_date(7'd5, 4'd0, 5'd10), pack_time(5'd8, 6'd0, 5'd0));
    send_req(pack_date(7'd5, 4'd13, 5'd10), pack_time(5'd8, 6'd0, 5'd0));
    send_req(pack_date(7'd5, 4'd15, 5'd10), pack_time(5'd8, 6'd0, 5'd0));
    send_req(pack_date(7'd5, MON_JUN, 5'd0), pack_time(5'd8, 6'd0, 5'd0));
    send_req(pack_date(7'd64, MON_JUN, 5'd15), pack_time(5'd24, 6'd0, 5'd0));
    send_req(pack_date(7'd64, MON_JUN, 5'd15), pack_time(5'd31, 6'd59, 5'd29));
    send_req(pack_date(7'd64, MON_JUN, 5'd15), pack_time(5'd23, 6'd60, 5'd0));
    send_req(pack_date(7'd64, MON_JUN, 5'd15), pack_time(5'd23, 6'd63, 5'd0));
    send_req(pack_date(7'd64, MON_JUN, 5'd15), pack_time(5'd23, 6'd59, 5'd30));
    send_req(pack_date(7'd64, MON_JUN, 5'd15), pack_time(5'd23, 6'd59, 5'd31));
    send_req(pack_date(7'd127, MON_JAN, 5'd1), pack_time(5'd0, 6'd0, 5'd0));
    send_req(pack_date(7'd0, MON_DEC, 5'd31), pack_time(5'd23, 6'd59, 5'd29));
    drain();

    run_phase(0, 0, PHASE_ITEMS);
    run_phase(75, 0, PHASE_ITEMS);
    run_phase(0, 75, PHASE_ITEMS);
    run_phase(19, 19, PHASE_ITEMS);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
